FILE: hdl/eur_pkg.sv
// eur_pkg: shared types, codes and reset constants for the ultrasonic echo ranger
// no dependencies; imported by eur_channel, ultrasonic_echo_ranger_core, echo_ranger_checker and testbench
package eur_pkg;

    localparam int unsigned MAX_CHANNELS  = 2;
    localparam int unsigned DEF_CHANNELS  = 2;
    localparam int unsigned COUNT_W       = 20;
    localparam int unsigned TRIG_W        = 8;
    localparam int unsigned Q8_SCALE_W    = 13;
    localparam int unsigned Q8_SHIFT      = 10;
    localparam int unsigned PROD_W        = COUNT_W + Q8_SCALE_W;
    localparam int unsigned SCALED_W      = PROD_W - Q8_SHIFT;

    localparam logic [Q8_SCALE_W-1:0] Q8_SCALE = 13'd4457;
    localparam logic [COUNT_W-1:0]    COUNT_MAX = '1;

    localparam logic [TRIG_W-1:0]  RST_TRIGGER_WIDTH = 8'd15;
    localparam logic [COUNT_W-1:0] RST_TIMEOUT       = 20'd100000;
    localparam logic [COUNT_W-1:0] RST_MAX_PULSE     = 20'd26470;

    typedef enum logic [1:0] {
        CFG_TRIGGER_WIDTH = 2'd0,
        CFG_TIMEOUT       = 2'd1,
        CFG_MAX_PULSE     = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_HIGH = 2'd3
    } phase_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    typedef struct packed {
        logic [TRIG_W-1:0]  trigger_width_us;
        logic [COUNT_W-1:0] timeout_us;
        logic [COUNT_W-1:0] max_pulse_us;
    } cfg_t;

    typedef struct packed {
        logic [1:0] command;
        logic       echo_one;
        logic       echo_two;
    } item_t;

    typedef struct packed {
        logic               trig_one;
        logic               trig_two;
        logic               done_one;
        logic               done_two;
        logic [COUNT_W-1:0] range_one;
        logic [COUNT_W-1:0] range_two;
        logic [1:0]         status_one;
        logic [1:0]         status_two;
    } result_t;

    typedef struct packed {
        logic               trig;
        logic               done;
        logic [COUNT_W-1:0] range;
        logic [1:0]         status;
    } chan_out_t;

endpackage

FILE: hdl/eur_channel.sv
// eur_channel: one ranging channel, trigger sequencer plus echo pulse timer
// depends on eur_pkg; instantiated by ultrasonic_echo_ranger_core
module eur_channel
    import eur_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  logic      start,
    input  logic      echo,
    input  cfg_t      cfg,
    output chan_out_t chan_out
);

    phase_t               phase_reg, phase_next;
    logic [COUNT_W-1:0]   wait_reg, wait_next;
    logic [COUNT_W-1:0]   pulse_reg, pulse_next;
    logic                 echo_prev_reg;

    logic [COUNT_W-1:0]   wait_inc;
    logic [COUNT_W-1:0]   pulse_inc;
    logic [PROD_W-1:0]    product;
    logic [SCALED_W-1:0]  scaled;
    logic [COUNT_W-1:0]   range_sat;
    logic                 rise;
    logic                 fall;
    logic                 trig_end;
    logic                 timed_out;

    assign rise      = echo && !echo_prev_reg;
    assign fall      = !echo && echo_prev_reg;
    assign wait_inc  = (wait_reg == COUNT_MAX) ? wait_reg : wait_reg + 1'b1;
    assign pulse_inc = (pulse_reg == COUNT_MAX) ? pulse_reg : pulse_reg + 1'b1;
    assign trig_end  = wait_inc >= {{(COUNT_W-TRIG_W){1'b0}}, cfg.trigger_width_us};
    assign timed_out = wait_inc >= cfg.timeout_us;

    // q8 cm = pulse * 4457 >> 10, saturated to the field width
    assign product   = PROD_W'(pulse_inc) * PROD_W'(Q8_SCALE);
    assign scaled    = product[PROD_W-1:Q8_SHIFT];
    assign range_sat = (|scaled[SCALED_W-1:COUNT_W]) ? COUNT_MAX : scaled[COUNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            wait_reg      <= '0;
            pulse_reg     <= '0;
            echo_prev_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            wait_reg      <= wait_next;
            pulse_reg     <= pulse_next;
            echo_prev_reg <= echo;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        wait_next       = wait_reg;
        pulse_next      = pulse_reg;
        chan_out.trig   = 1'b0;
        chan_out.done   = 1'b0;
        chan_out.range  = '0;
        chan_out.status = ST_OK;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    chan_out.trig = 1'b1;
                    // a width of zero or one ends the trigger after this tick
                    if (cfg.trigger_width_us <= TRIG_W'(1))
                    begin
                        phase_next = PH_WAIT;
                        wait_next  = '0;
                    end
                    else
                    begin
                        phase_next = PH_TRIG;
                        wait_next  = COUNT_W'(1);
                    end
                end
            end
            PH_TRIG:
            begin
                chan_out.trig = 1'b1;
                wait_next     = wait_inc;
                if (trig_end)
                begin
                    phase_next = PH_WAIT;
                    wait_next  = '0;
                end
            end
            PH_WAIT:
            begin
                wait_next = wait_inc;
                if (rise)
                begin
                    phase_next = PH_HIGH;
                    pulse_next = '0;
                end
                else if (timed_out)
                begin
                    phase_next      = PH_IDLE;
                    chan_out.done   = 1'b1;
                    chan_out.status = ST_TIMEOUT;
                end
            end
            PH_HIGH:
            begin
                wait_next  = wait_inc;
                pulse_next = pulse_inc;
                // a fall on the timeout tick still counts as a measurement
                if (fall)
                begin
                    phase_next    = PH_IDLE;
                    chan_out.done = 1'b1;
                    if (pulse_inc > cfg.max_pulse_us)
                    begin
                        chan_out.status = ST_RANGE;
                    end
                    else
                    begin
                        chan_out.range = range_sat;
                    end
                end
                else if (timed_out)
                begin
                    phase_next      = PH_IDLE;
                    chan_out.done   = 1'b1;
                    chan_out.status = ST_TIMEOUT;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/ultrasonic_echo_ranger_core.sv
// ultrasonic_echo_ranger_core: top level, config registers, channels and result register
// depends on eur_pkg and eur_channel
// timing: a result is registered and presented in the cycle after its input transfer
// throughput: one item per cycle; the single result register refills in the
// cycle it is emptied, so only a stalled result holds off the input
// reset: asynchronous active-low; all channels idle, counters and echo history
// cleared, config registers back to 15 / 100000 / 26470, no result pending
module ultrasonic_echo_ranger_core
    import eur_pkg::*;
#(
    parameter int unsigned CHANNELS = DEF_CHANNELS
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input item channel, one microsecond tick per transfer
    input  logic               item_valid,
    output logic               item_ready,
    input  item_t              item,
    // result channel, one result per input tick
    output logic               result_valid,
    input  logic               result_ready,
    output result_t            result,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [COUNT_W-1:0] cfg_data
);

    cfg_t      cfg_reg;
    result_t   result_reg, result_next;
    logic      result_valid_reg;
    logic      advance;
    chan_out_t chan_out [MAX_CHANNELS];
    logic      start    [MAX_CHANNELS];
    logic      echo     [MAX_CHANNELS];

    // configuration registers, always ready; a write takes effect at its transfer;
    // the host must issue writes only between measurements, which the block does not enforce
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_width_us <= RST_TRIGGER_WIDTH;
            cfg_reg.timeout_us       <= RST_TIMEOUT;
            cfg_reg.max_pulse_us     <= RST_MAX_PULSE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TRIGGER_WIDTH: cfg_reg.trigger_width_us <= cfg_data[TRIG_W-1:0];
                CFG_TIMEOUT:       cfg_reg.timeout_us       <= cfg_data;
                CFG_MAX_PULSE:     cfg_reg.max_pulse_us     <= cfg_data;
                default:           ;  // unmapped index, write dropped
            endcase
        end
    end

    // the input side stalls only when the held result is not being taken
    assign item_ready = !result_valid_reg || result_ready;
    assign advance    = item_valid && item_ready;

    assign start[0] = item.command[0];
    assign start[1] = item.command[1];
    assign echo[0]  = item.echo_one;
    assign echo[1]  = item.echo_two;

    // channels present in this build; the rest read as idle with zero outputs
    for (genvar c = 0; c < MAX_CHANNELS; c++)
    begin : g_chan
        if (c < CHANNELS)
        begin : g_on
            eur_channel u_chan (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .start    (start[c]),
                .echo     (echo[c]),
                .cfg      (cfg_reg),
                .chan_out (chan_out[c])
            );
        end
        else
        begin : g_off
            assign chan_out[c] = '0;
        end
    end

    // pack both channels into the result item
    always_comb
    begin
        result_next.trig_one   = chan_out[0].trig;
        result_next.trig_two   = chan_out[1].trig;
        result_next.done_one   = chan_out[0].done;
        result_next.done_two   = chan_out[1].done;
        result_next.range_one  = chan_out[0].range;
        result_next.range_two  = chan_out[1].range;
        result_next.status_one = chan_out[0].status;
        result_next.status_two = chan_out[1].status;
    end

    // result register; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // every input transfer leaves a result pending on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("input transfer did not produce a pending result");

    // channel one, when it did not finish, reports zero range and ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_reg.done_one) |->
            (result_reg.range_one == '0 && result_reg.status_one == ST_OK))
        else $error("channel one reports a range without finishing");

    // a channel never drives its trigger in the same tick it finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |->
            !(result_reg.trig_one && result_reg.done_one) &&
            !(result_reg.trig_two && result_reg.done_two))
        else $error("trigger and done asserted together");

    // a channel two error status always carries a zero range and a done
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.status_two != ST_OK) |->
            (result_reg.range_two == '0 && result_reg.done_two))
        else $error("channel two error result carries a range");

endmodule

FILE: verif/echo_ranger_checker.sv
// echo_ranger_checker: watches item, result and config transfers of the ranger core,
// predicts every tick's result and compares it field by field
// depends on eur_pkg
`timescale 1ns / 1ps

module echo_ranger_checker
    import eur_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_ready,
    input  item_t              item,
    input  logic               result_valid,
    input  logic               result_ready,
    input  result_t            result,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [COUNT_W-1:0] cfg_data,
    output int unsigned        mismatches,
    output int unsigned        pending
);

    localparam int unsigned REPORT_LIMIT = 10;

    // register copies
    logic [TRIG_W-1:0]  trig_width;
    logic [COUNT_W-1:0] timeout_ticks;
    logic [COUNT_W-1:0] max_pulse;

    // per-channel ranging state
    phase_t             ch_phase     [2];
    logic [COUNT_W-1:0] ch_wait      [2];
    logic [COUNT_W-1:0] ch_pulse     [2];
    logic               ch_echo_prev [2];

    result_t     predicted_results [$];
    result_t     want;
    result_t     next_tick;
    chan_out_t   chan_a;
    chan_out_t   chan_b;
    int unsigned fault_count;
    int unsigned result_index;

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // one tick of one channel, updates that channel's state
    function automatic chan_out_t advance_channel(input int c, input logic start,
                                                  input logic echo);
        chan_out_t           o;
        logic                rise;
        logic                fall;
        logic [PROD_W-1:0]   prod;
        logic [SCALED_W-1:0] scaled;
        o    = '0;
        rise = echo & ~ch_echo_prev[c];
        fall = ~echo & ch_echo_prev[c];
        case (ch_phase[c])
            PH_IDLE:
            begin
                if (start)
                begin
                    o.trig     = 1'b1;
                    ch_wait[c] = COUNT_W'(1);
                    if (ch_wait[c] >= COUNT_W'(trig_width))
                    begin
                        ch_phase[c] = PH_WAIT;
                        ch_wait[c]  = '0;
                    end
                    else
                    begin
                        ch_phase[c] = PH_TRIG;
                    end
                end
            end
            PH_TRIG:
            begin
                o.trig     = 1'b1;
                ch_wait[c] = bump(ch_wait[c]);
                if (ch_wait[c] >= COUNT_W'(trig_width))
                begin
                    ch_phase[c] = PH_WAIT;
                    ch_wait[c]  = '0;
                end
            end
            PH_WAIT:
            begin
                ch_wait[c] = bump(ch_wait[c]);
                if (rise)
                begin
                    ch_phase[c] = PH_HIGH;
                    ch_pulse[c] = '0;
                end
                else if (ch_wait[c] >= timeout_ticks)
                begin
                    ch_phase[c] = PH_IDLE;
                    o.done      = 1'b1;
                    o.status    = ST_TIMEOUT;
                end
            end
            default:
            begin
                ch_wait[c]  = bump(ch_wait[c]);
                ch_pulse[c] = bump(ch_pulse[c]);
                if (fall)
                begin
                    ch_phase[c] = PH_IDLE;
                    o.done      = 1'b1;
                    if (ch_pulse[c] > max_pulse)
                    begin
                        o.status = ST_RANGE;
                    end
                    else
                    begin
                        prod     = PROD_W'(ch_pulse[c]) * PROD_W'(Q8_SCALE);
                        scaled   = prod[PROD_W-1:Q8_SHIFT];
                        o.range  = (scaled > SCALED_W'(COUNT_MAX)) ? COUNT_MAX
                                                                   : scaled[COUNT_W-1:0];
                        o.status = ST_OK;
                    end
                end
                else if (ch_wait[c] >= timeout_ticks)
                begin
                    ch_phase[c] = PH_IDLE;
                    o.done      = 1'b1;
                    o.status    = ST_TIMEOUT;
                end
            end
        endcase
        ch_echo_prev[c] = echo;
        return o;
    endfunction

    task automatic check_field(input string name, input logic [COUNT_W-1:0] exp_val,
                               input logic [COUNT_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            if (fault_count < REPORT_LIMIT)
                $display("result %0d %s: expected %0h, actual %0h",
                         result_index, name, exp_val, act_val);
            fault_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_width    = RST_TRIGGER_WIDTH;
            timeout_ticks = RST_TIMEOUT;
            max_pulse     = RST_MAX_PULSE;
            for (int c = 0; c < 2; c++)
            begin
                ch_phase[c]     = PH_IDLE;
                ch_wait[c]      = '0;
                ch_pulse[c]     = '0;
                ch_echo_prev[c] = 1'b0;
            end
            predicted_results.delete();
            fault_count  = 0;
            result_index = 0;
            mismatches  <= 0;
            pending     <= 0;
        end
        else
        begin
            // result transfer against the oldest prediction
            if (result_valid && result_ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    if (fault_count < REPORT_LIMIT)
                        $display("result %0d arrived with nothing predicted: %0h",
                                 result_index, result);
                    fault_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("trig_one",   COUNT_W'(want.trig_one),   COUNT_W'(result.trig_one));
                    check_field("trig_two",   COUNT_W'(want.trig_two),   COUNT_W'(result.trig_two));
                    check_field("done_one",   COUNT_W'(want.done_one),   COUNT_W'(result.done_one));
                    check_field("done_two",   COUNT_W'(want.done_two),   COUNT_W'(result.done_two));
                    check_field("range_one",  want.range_one,            result.range_one);
                    check_field("range_two",  want.range_two,            result.range_two);
                    check_field("status_one", COUNT_W'(want.status_one), COUNT_W'(result.status_one));
                    check_field("status_two", COUNT_W'(want.status_two), COUNT_W'(result.status_two));
                end
                result_index++;
            end
            // each accepted tick advances both channels
            if (item_valid && item_ready)
            begin
                chan_a = advance_channel(0, item.command[0], item.echo_one);
                chan_b = advance_channel(1, item.command[1], item.echo_two);
                next_tick.trig_one   = chan_a.trig;
                next_tick.trig_two   = chan_b.trig;
                next_tick.done_one   = chan_a.done;
                next_tick.done_two   = chan_b.done;
                next_tick.range_one  = chan_a.range;
                next_tick.range_two  = chan_b.range;
                next_tick.status_one = chan_a.status;
                next_tick.status_two = chan_b.status;
                predicted_results.push_back(next_tick);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_TRIGGER_WIDTH: trig_width    = cfg_data[TRIG_W-1:0];
                    CFG_TIMEOUT:       timeout_ticks = cfg_data;
                    CFG_MAX_PULSE:     max_pulse     = cfg_data;
                    default:           ;
                endcase
            end
            mismatches <= fault_count;
            pending    <= predicted_results.size();
        end
    end

endmodule

FILE: verif/testbench.sv
// testbench: stimulus, clock, reset and verdict for ultrasonic_echo_ranger_core
// depends on eur_pkg, ultrasonic_echo_ranger_core and echo_ranger_checker
`timescale 1ns / 1ps

module testbench;
    import eur_pkg::*;

    localparam longint unsigned CYCLE_LIMIT   = 3_000_000;
    localparam int              HOLD_CYCLES   = 400;
    localparam int              SETTLE_CYCLES = 4;
    localparam int              PHASE_ITEMS   = 150;
    localparam int              MAX_GAP       = 20;
    localparam int              LONG_PULSE    = 100;
    // register index with no register behind it
    localparam logic [1:0]      CFG_SPARE     = 2'd3;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_ready;
    item_t              item         = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    result_t            result;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index    = '0;
    logic [COUNT_W-1:0] cfg_data     = '0;

    int unsigned mismatches;
    int unsigned pending;

    // idling knobs, percent of cycles
    int              idle_pct  = 0;
    int              stall_pct = 0;
    bit              long_hold_request = 1'b0;
    int unsigned     items_sent  = 0;
    longint unsigned cycle_count = 0;

    // shadow of the register values, steers the echo patterns
    logic [TRIG_W-1:0]  cur_trig    = RST_TRIGGER_WIDTH;
    logic [COUNT_W-1:0] cur_timeout = RST_TIMEOUT;
    logic [COUNT_W-1:0] cur_max     = RST_MAX_PULSE;

    ultrasonic_echo_ranger_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    echo_ranger_checker checker_inst
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("ultrasonic_echo_ranger_core: mismatch");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    // so the result register fills and the item channel backs up
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_request)
            begin
                long_hold_request = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                result_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // one tick transfer, with a random idle gap in front of it
    task automatic send_item(input logic [1:0] command, input logic echo_one,
                             input logic echo_two);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= item_t'({command, echo_one, echo_two});
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        items_sent++;
    endtask

    // config transfer, valid dropped after it
    task automatic write_reg(input logic [1:0] index, input logic [COUNT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (index == CFG_TRIGGER_WIDTH)
            cur_trig = data[TRIG_W-1:0];
        else if (index == CFG_TIMEOUT)
            cur_timeout = data;
        else if (index == CFG_MAX_PULSE)
            cur_max = data;
    endtask

    // stop offering and wait for every predicted result to be taken
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // drives len ticks; each channel gets a start, an echo window from rise to fall,
    // or random echo when noisy, and sparse extra starts that mostly land while busy
    task automatic drive_pattern(input int start_a, input int rise_a, input int fall_a,
                                 input bit noisy_a, input int start_b, input int rise_b,
                                 input int fall_b, input bit noisy_b, input int len);
        logic [1:0] command;
        logic       echo_a;
        logic       echo_b;
        for (int t = 0; t < len; t++)
        begin
            command[0] = (t == start_a) || ($urandom_range(0, noisy_a ? 5 : 15) == 0);
            command[1] = (t == start_b) || ($urandom_range(0, noisy_b ? 5 : 15) == 0);
            echo_a = noisy_a ? 1'($urandom_range(0, 1)) : (t >= rise_a && t < fall_a);
            echo_b = noisy_b ? 1'($urandom_range(0, 1)) : (t >= rise_b && t < fall_b);
            send_item(command, echo_a, echo_b);
        end
    endtask

    // one burst of measurements with random shapes on both channels
    task automatic plan_burst();
        int start_at [2];
        int rise_at  [2];
        int fall_at  [2];
        int stop_at  [2];
        bit noisy    [2];
        int w;
        int kind;
        int delay;
        w = (cur_trig == 0) ? 1 : int'(cur_trig);
        for (int c = 0; c < 2; c++)
        begin
            kind        = $urandom_range(0, 9);
            start_at[c] = $urandom_range(0, 3);
            rise_at[c]  = 0;
            fall_at[c]  = 0;
            noisy[c]    = 1'b0;
            if (kind <= 5)
            begin
                // clean echo; now and then late enough to time out
                if ($urandom_range(0, 3) == 0)
                    delay = $urandom_range(0, int'(cur_timeout) + 4);
                else
                    delay = $urandom_range(0, int'(cur_timeout) / 3);
                rise_at[c] = start_at[c] + w + delay;
                fall_at[c] = rise_at[c] + $urandom_range(1, int'(cur_max) + 6);
                stop_at[c] = fall_at[c] + $urandom_range(1, 3);
            end
            else if (kind == 6)
            begin
                // echo already high as the trigger ends, no rise seen
                rise_at[c] = start_at[c] + w - 1;
                fall_at[c] = rise_at[c] + $urandom_range(1, 6);
                stop_at[c] = start_at[c] + w + int'(cur_timeout) + 3;
            end
            else if (kind == 7)
            begin
                // no echo at all
                stop_at[c] = start_at[c] + w + int'(cur_timeout) + 2;
            end
            else
            begin
                noisy[c]   = 1'b1;
                stop_at[c] = $urandom_range(8, 40);
            end
        end
        drive_pattern(start_at[0], rise_at[0], fall_at[0], noisy[0],
                      start_at[1], rise_at[1], fall_at[1], noisy[1],
                      (stop_at[0] > stop_at[1]) ? stop_at[0] : stop_at[1]);
    endtask

    // random phase: new short timings, bursts, then quiet ticks so both channels idle
    task automatic random_phase(input int idle, input int stall, input bit hold);
        logic [COUNT_W-1:0] width_data;
        int unsigned        target;
        idle_pct  = idle;
        stall_pct = stall;
        width_data = COUNT_W'($urandom());
        width_data[TRIG_W-1:0] = TRIG_W'($urandom_range(0, 6));
        write_reg(CFG_TRIGGER_WIDTH, width_data);
        write_reg(CFG_TIMEOUT, COUNT_W'($urandom_range(15, 60)));
        write_reg(CFG_MAX_PULSE, COUNT_W'($urandom_range(3, 30)));
        write_reg(CFG_SPARE, COUNT_W'($urandom()));
        if (hold)
            long_hold_request = 1'b1;
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target)
            plan_burst();
        repeat (int'(cur_timeout) + 10)
            send_item(2'b00, 1'b0, 1'b0);
        settle();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, plain ticks with echo edges on idle channels
        send_item(2'b00, 1'b1, 1'b1);
        send_item(2'b00, 1'b0, 1'b0);
        settle();

        // zero trigger width and zero timeout: both channels time out right away
        write_reg(CFG_TRIGGER_WIDTH, '0);
        write_reg(CFG_TIMEOUT, '0);
        write_reg(CFG_MAX_PULSE, '0);
        send_item(2'b11, 1'b0, 1'b0);
        send_item(2'b00, 1'b0, 1'b0);
        settle();

        // short timings for the hand-built sequence
        write_reg(CFG_TRIGGER_WIDTH, COUNT_W'(3));
        write_reg(CFG_TIMEOUT, COUNT_W'(6));
        write_reg(CFG_MAX_PULSE, COUNT_W'(3));
        // start both, restart while busy, echo edges during the trigger
        send_item(2'b11, 1'b1, 1'b0);
        send_item(2'b11, 1'b1, 1'b1);
        send_item(2'b00, 1'b1, 1'b0);
        // channel one high as the trigger ends, then a fall with no rise
        send_item(2'b00, 1'b1, 1'b0);
        send_item(2'b00, 1'b0, 1'b1);
        // channel two short pulse in range, channel one rises
        send_item(2'b00, 1'b1, 1'b1);
        send_item(2'b00, 1'b1, 1'b0);
        send_item(2'b00, 1'b1, 1'b0);
        // channel one falls on the tick its timeout is reached; channel two restarts
        send_item(2'b10, 1'b0, 1'b0);
        // channel one restarts, pulse too long; channel two never sees an echo
        send_item(2'b01, 1'b0, 1'b0);
        send_item(2'b00, 1'b0, 1'b0);
        send_item(2'b00, 1'b0, 1'b0);
        send_item(2'b00, 1'b1, 1'b0);
        send_item(2'b00, 1'b1, 1'b0);
        send_item(2'b00, 1'b1, 1'b0);
        send_item(2'b00, 1'b1, 1'b0);
        send_item(2'b00, 1'b0, 1'b0);
        send_item(2'b00, 1'b0, 1'b0);
        settle();

        // random part, one idling mix per phase
        random_phase(0, 0, 1'b1);
        random_phase(62, 0, 1'b0);
        random_phase(25, 25, 1'b0);
        random_phase(0, 62, 1'b0);

        // widest settings: longest trigger, timeout and range limit fully open
        idle_pct  = 0;
        stall_pct = 0;
        write_reg(CFG_TRIGGER_WIDTH, COUNT_W'(8'hFF));
        write_reg(CFG_TIMEOUT, COUNT_MAX);
        write_reg(CFG_MAX_PULSE, COUNT_MAX);
        drive_pattern(0, 258, 258 + LONG_PULSE, 1'b0, 1, 261, 361, 1'b0, 262 + LONG_PULSE);
        settle();

        if (mismatches == 0 && pending == 0)
            $display("ultrasonic_echo_ranger_core: match");
        else
            $display("ultrasonic_echo_ranger_core: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/eur_pkg.sv
hdl/eur_channel.sv
hdl/ultrasonic_echo_ranger_core.sv
verif/echo_ranger_checker.sv
verif/testbench.sv
